// ----- rtl/nll_pkg.sv -----
// ----------------------------------------------------------------------------
// nll_pkg: numeric literal lexer package
// Status and mode codes, lexer state record and character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nll_pkg;

  typedef enum logic [1:0] {
    StCont = 2'd0,
    StDone = 2'd1,
    StEnd  = 2'd2,
    StErr  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ModeZero = 3'd0,
    ModeBin  = 3'd1,
    ModeOct  = 3'd2,
    ModeDec  = 3'd3,
    ModeHex  = 3'd4,
    ModeSuf  = 3'd5
  } mode_e;

  localparam int unsigned CharW = 8;

  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    logic       started;
    mode_e      mode;
    logic       dot_seen;
    logic       exp_seen;
    logic       u_seen;
    logic       l_seen;
    logic       f_seen;
    char_t      prev_char;
    logic [1:0] chars_taken;
  } lex_state_t;

  localparam lex_state_t LexStateClear = '{
    started:     1'b0,
    mode:        ModeZero,
    dot_seen:    1'b0,
    exp_seen:    1'b0,
    u_seen:      1'b0,
    l_seen:      1'b0,
    f_seen:      1'b0,
    prev_char:   '0,
    chars_taken: 2'd0
  };

  // Prefix length "0x" / "0b": an empty prefix has exactly two bytes taken.
  localparam logic [1:0] PrefixLen = 2'd2;

  function automatic logic is_dig(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_oct(input char_t c);
    return (c >= "0") && (c <= "7");
  endfunction

  function automatic logic is_bin(input char_t c);
    return (c == "0") || (c == "1");
  endfunction

  function automatic logic is_hex(input char_t c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_suf(input char_t c);
    return (c == "u") || (c == "U") || (c == "l") || (c == "L") ||
           (c == "f") || (c == "F");
  endfunction

  function automatic logic is_sign(input char_t c);
    return (c == "+") || (c == "-");
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nll_intf.sv -----
// ----------------------------------------------------------------------------
// nll_intf: numeric literal lexer channels
// Valid/ready channels for the character stream and the per-character result.
// ----------------------------------------------------------------------------
`default_nettype none

interface nll_char_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] char_in;

  modport source (output valid, output start_req, output char_in, input ready);
  modport sink   (input valid, input start_req, input char_in, output ready);
endinterface

interface nll_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status_code;
  logic [2:0] mode_out;
  logic       has_dot;
  logic       has_exponent;
  logic       unsigned_suffix;
  logic       long_suffix;
  logic       float_suffix;

  modport source (output valid, output status_code, output mode_out, output has_dot,
                  output has_exponent, output unsigned_suffix, output long_suffix,
                  output float_suffix, input ready);
  modport sink   (input valid, input status_code, input mode_out, input has_dot,
                  input has_exponent, input unsigned_suffix, input long_suffix,
                  input float_suffix, output ready);
endinterface

`default_nettype wire

// ----- rtl/numeric_literal_lexer_unit.sv -----
// ----------------------------------------------------------------------------
// numeric_literal_lexer_unit: C-style numeric literal lexer
// Takes one character per transfer and returns one status/mode/flags result.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  in_i     | in  | start_req, char_in                        | valid/ready
//  out_o    | out | status_code, mode_out, has_dot,           | valid/ready
//           |     | has_exponent, unsigned/long/float_suffix  |
//
//  Two stages: an input register, then the lexer step feeding a result
//  register. A character is held in the input register, then its result
//  in the result register. Throughput is one character per cycle while
//  out_o is ready; the limit is the lexer state loop, which updates as
//  a character moves to the result. Reset clears the lexer state and
//  both stage valid bits. A stalled result holds the pipe; the input
//  stage still takes a character when it is empty or moves on that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_literal_lexer_unit
  import nll_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nll_char_if.sink    in_i,
  nll_res_if.source   out_o
);

  // Input stage
  logic  in_vld_q;
  logic  in_start_q;
  char_t in_char_q;

  // Result stage
  logic       res_vld_q;
  status_e    res_status_q;
  lex_state_t res_state_q;

  // Lexer state
  lex_state_t state_q, state_d;
  status_e    status;

  logic advance;   // input stage moves into the result stage
  logic in_take;   // input transfer this cycle
  logic in_ready;

  assign advance  = in_vld_q && (!res_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;
  assign in_take  = in_i.valid && in_ready;

  assign in_i.ready = in_ready;

  // One lexer step. Some rejecting paths still leave state behind: a bad
  // first character marks the literal started, and a suffix letter moves the
  // mode to suffix even when the suffix itself is refused.
  always_comb begin
    lex_state_t base;
    logic       suf_chk;
    base    = in_start_q ? LexStateClear : state_q;
    state_d = base;
    status  = StCont;
    suf_chk = 1'b0;

    if (in_char_q == '0) begin
      status = StErr;   // end of input
    end else if (!base.started) begin
      state_d.started = 1'b1;
      if (in_char_q != "0") begin
        if (!is_dig(in_char_q)) begin
          status = StErr;
        end else begin
          state_d.mode = ModeDec;
        end
      end
    end else begin
      unique case (base.mode)
        ModeZero: begin
          if ((in_char_q == "x") || (in_char_q == "X")) begin
            state_d.mode = ModeHex;
          end else if ((in_char_q == "b") || (in_char_q == "B")) begin
            state_d.mode = ModeBin;
          end else if (is_oct(in_char_q)) begin
            state_d.mode = ModeOct;
          end else if (in_char_q == ".") begin
            state_d.mode     = ModeDec;
            state_d.dot_seen = 1'b1;
          end else begin
            status = StEnd;
          end
        end
        ModeDec: begin
          if (!is_dig(in_char_q)) begin
            if (in_char_q == ".") begin
              if (base.exp_seen || base.dot_seen) status = StErr;
              else state_d.dot_seen = 1'b1;
            end else if (in_char_q == "e") begin
              if (base.exp_seen) status = StErr;
              else state_d.exp_seen = 1'b1;
            end else if (is_suf(in_char_q)) begin
              state_d.mode = ModeSuf;
              suf_chk      = 1'b1;
            end else if (is_sign(in_char_q)) begin
              if (base.prev_char != "e") status = StEnd;
            end else if ((base.exp_seen && is_sign(base.prev_char)) ||
                         (base.prev_char == ".")) begin
              status = StErr;   // dangling point or exponent sign
            end else begin
              status = StEnd;
            end
          end
        end
        ModeHex: begin
          if (!base.exp_seen) begin
            if (!is_hex(in_char_q)) begin
              if (in_char_q == ".") begin
                if (base.dot_seen) status = StErr;
                else state_d.dot_seen = 1'b1;
              end else if (in_char_q == "p") begin
                if (base.chars_taken == PrefixLen) status = StErr;
                else state_d.exp_seen = 1'b1;
              end else if (is_suf(in_char_q)) begin
                state_d.mode = ModeSuf;
                suf_chk      = 1'b1;
              end else if ((base.chars_taken == PrefixLen) ||
                           (base.prev_char == ".")) begin
                status = StErr;   // empty prefix or dangling point
              end else begin
                status = StEnd;
              end
            end
          end else if (!is_sign(in_char_q)) begin
            status = StErr;   // hex exponent needs a sign
          end else begin
            state_d.mode = ModeDec;
          end
        end
        ModeOct: begin
          if (!is_oct(in_char_q)) begin
            if (is_suf(in_char_q)) begin
              state_d.mode = ModeSuf;
              suf_chk      = 1'b1;
            end else begin
              status = StEnd;
            end
          end
        end
        ModeBin: begin
          if (!is_bin(in_char_q)) begin
            if (is_suf(in_char_q)) begin
              state_d.mode = ModeSuf;
              suf_chk      = 1'b1;
            end else if (base.chars_taken == PrefixLen) begin
              status = StErr;
            end else begin
              status = StEnd;
            end
          end
        end
        ModeSuf: suf_chk = 1'b1;
        default: status = StEnd;
      endcase

      if (suf_chk) begin
        if ((in_char_q == "u") || (in_char_q == "U")) begin
          if (base.u_seen) status = StErr;
          else state_d.u_seen = 1'b1;
        end else if ((in_char_q == "l") || (in_char_q == "L")) begin
          if (base.l_seen) status = StErr;
          else state_d.l_seen = 1'b1;
        end else if ((in_char_q == "f") || (in_char_q == "F")) begin
          if (base.u_seen || base.l_seen) status = StErr;
          else state_d.f_seen = 1'b1;
        end else begin
          status = StEnd;
        end
      end
    end

    // Consumed character: remember it and bump the saturating count.
    if (status == StCont) begin
      state_d.prev_char = in_char_q;
      if (base.chars_taken != 2'd3) state_d.chars_taken = base.chars_taken + 2'd1;
      if ((state_d.u_seen && state_d.l_seen) || state_d.f_seen) status = StDone;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= LexStateClear;
    end else begin
      if (in_ready) in_vld_q <= in_i.valid;
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_start_q <= in_i.start_req;
      in_char_q  <= in_i.char_in;
    end
    if (advance) begin
      res_status_q <= status;
      res_state_q  <= state_d;
    end
  end

  assign out_o.valid           = res_vld_q;
  assign out_o.status_code     = res_status_q;
  assign out_o.mode_out        = res_state_q.mode;
  assign out_o.has_dot         = res_state_q.dot_seen;
  assign out_o.has_exponent    = res_state_q.exp_seen;
  assign out_o.unsigned_suffix = res_state_q.u_seen;
  assign out_o.long_suffix     = res_state_q.l_seen;
  assign out_o.float_suffix    = res_state_q.f_seen;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: numeric literal lexer unit testbench
// Streams C-style numeric literals, one character per transfer, into the lexer.
// A local lexer model predicts every status/mode/flags result, and a monitor
// compares them in order. Both channels idle at random, the receiver holds
// off once for a long stretch, and the sender drains the pipe early and midway.
// ----------------------------------------------------------------------------

module tb
  import nll_pkg::*;
;

  localparam int NumItems  = 1800;
  localparam int WdLimit   = 3000;  // cycles with no transfer on either side
  localparam int MaxShown  = 10;
  localparam int HoldAt    = 500;   // result count that starts the long hold-off
  localparam int HoldLen   = 300;
  localparam int TailWait  = 10;

  // One character transfer as queued for the driver.
  typedef struct packed {
    logic  drain_first;  // wait until every expected result is in before sending
    logic  start_req;
    char_t ch;
  } char_item_t;

  // One lexer result.
  typedef struct packed {
    status_e status;
    mode_e   mode;
    logic    dot;
    logic    expo;
    logic    u_suf;
    logic    l_suf;
    logic    f_suf;
  } lex_res_t;

  logic clk_i;
  logic rst_ni;

  nll_char_if in_if ();
  nll_res_if  out_if ();

  numeric_literal_lexer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  char_item_t pend_q[$];
  lex_res_t   lex_res_q[$];
  lex_state_t lx;

  bit  drain_pending;
  bit  lit_first;
  int  n_items;
  int  err_cnt;
  int  res_cnt;
  int  idle_cycles;
  int  send_gap;
  int  send_calm;
  int  recv_gap;
  int  recv_calm;
  bit  did_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Lexer model
  // --------------------------------------------------------------------------
  function automatic logic ch_digit(input char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ch_octal(input char_t c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic ch_binary(input char_t c);
    return c == "0" || c == "1";
  endfunction

  function automatic logic ch_hexdig(input char_t c);
    return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic ch_suffix(input char_t c);
    return c == "u" || c == "U" || c == "l" || c == "L" || c == "f" || c == "F";
  endfunction

  function automatic logic ch_sign(input char_t c);
    return c == "+" || c == "-";
  endfunction

  // Classifies one non-zero character against the lexer state. Returns StCont
  // when it is to be consumed; flags and mode may change even on error.
  function automatic status_e lex_judge(input char_t c);
    if (!lx.started) begin
      // first character: started sticks even when it is not a digit
      lx.started = 1'b1;
      if (c != "0") begin
        if (!ch_digit(c)) return StErr;
        lx.mode = ModeDec;
      end
      return StCont;
    end
    case (lx.mode)
      ModeZero: begin
        if (c == "x" || c == "X") lx.mode = ModeHex;
        else if (c == "b" || c == "B") lx.mode = ModeBin;
        else if (ch_octal(c)) lx.mode = ModeOct;
        else if (c == ".") begin
          lx.mode     = ModeDec;
          lx.dot_seen = 1'b1;
        end else return StEnd;
        return StCont;
      end
      ModeDec: begin
        if (!ch_digit(c)) begin
          if (c == ".") begin
            if (lx.exp_seen || lx.dot_seen) return StErr;
            lx.dot_seen = 1'b1;
          end else if (c == "e") begin
            if (lx.exp_seen) return StErr;
            lx.exp_seen = 1'b1;
          end else if (ch_suffix(c)) begin
            lx.mode = ModeSuf;
          end else if (ch_sign(c)) begin
            if (lx.prev_char != "e") return StEnd;
          end else begin
            // dangling point or exponent sign
            if ((lx.exp_seen && ch_sign(lx.prev_char)) || lx.prev_char == ".") return StErr;
            return StEnd;
          end
        end
      end
      ModeHex: begin
        if (!lx.exp_seen) begin
          if (!ch_hexdig(c)) begin
            if (c == ".") begin
              if (lx.dot_seen) return StErr;
              lx.dot_seen = 1'b1;
            end else if (c == "p") begin
              if (lx.chars_taken == PrefixLen) return StErr;
              lx.exp_seen = 1'b1;
            end else if (ch_suffix(c)) begin
              lx.mode = ModeSuf;
            end else begin
              if (lx.chars_taken == PrefixLen || lx.prev_char == ".") return StErr;
              return StEnd;
            end
          end
        end else begin
          // hex exponent needs a sign, then it reads as decimal digits
          if (!ch_sign(c)) return StErr;
          lx.mode = ModeDec;
        end
      end
      ModeOct: begin
        if (!ch_octal(c)) begin
          if (ch_suffix(c)) lx.mode = ModeSuf;
          else return StEnd;
        end
      end
      ModeBin: begin
        if (!ch_binary(c)) begin
          if (ch_suffix(c)) lx.mode = ModeSuf;
          else if (lx.chars_taken == PrefixLen) return StErr;
          else return StEnd;
        end
      end
      ModeSuf: ;
      default: return StEnd;
    endcase

    if (lx.mode == ModeSuf) begin
      if (c == "u" || c == "U") begin
        if (lx.u_seen) return StErr;
        lx.u_seen = 1'b1;
      end else if (c == "l" || c == "L") begin
        if (lx.l_seen) return StErr;
        lx.l_seen = 1'b1;
      end else if (c == "f" || c == "F") begin
        if (lx.u_seen || lx.l_seen) return StErr;
        lx.f_seen = 1'b1;
      end else begin
        return StEnd;
      end
    end
    return StCont;
  endfunction

  // Advances the model by one accepted character and queues its result.
  task automatic lex_predict(input logic start, input char_t c);
    status_e  st;
    lex_res_t r;
    if (start) lx = LexStateClear;
    if (c == 8'h00) begin
      st = StErr;  // end of input, state untouched
    end else begin
      st = lex_judge(c);
      if (st == StCont) begin
        lx.prev_char = c;
        if (lx.chars_taken != 2'd3) lx.chars_taken = lx.chars_taken + 2'd1;
        if ((lx.u_seen && lx.l_seen) || lx.f_seen) st = StDone;
      end
    end
    r = '{st, lx.mode, lx.dot_seen, lx.exp_seen, lx.u_seen, lx.l_seen, lx.f_seen};
    lex_res_q.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_raw(input logic st, input char_t c);
    pend_q.push_back('{drain_pending, st, c});
    drain_pending = 1'b0;
    n_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_raw(i == 0, s[i]);
  endtask

  // Literal character: start on the first one, with a little corruption.
  task automatic push_lex(input char_t c);
    logic st;
    st = lit_first;
    lit_first = 1'b0;
    if ($urandom_range(0, 59) == 0) c = char_t'($urandom_range(0, 255));
    if ($urandom_range(0, 79) == 0) st = ~st;
    push_raw(st, c);
  endtask

  function automatic char_t rand_from(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic push_some(input string set, input int n);
    for (int i = 0; i < n; i++) push_lex(rand_from(set));
  endtask

  task automatic push_suffix();
    push_some("uUlLfF", $urandom_range(0, 3));
  endtask

  task automatic gen_literal();
    lit_first = 1'b1;
    case ($urandom_range(0, 5))
      0: begin  // decimal, optional fraction and exponent
        push_lex(rand_from("123456789"));
        push_some("0123456789", $urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          push_lex(".");
          push_some("0123456789", $urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
          push_lex(rand_from("eeeE"));
          if ($urandom_range(0, 1)) push_lex(rand_from("+-"));
          push_some("0123456789", $urandom_range(0, 3));
        end
        push_suffix();
      end
      1: begin  // hex, sometimes with an empty prefix
        push_lex("0");
        push_lex(rand_from("xX"));
        push_some("0123456789abcdefABCDEF", $urandom_range(0, 4));
        if ($urandom_range(0, 2) == 0) begin
          push_lex(".");
          push_some("0123456789abcdefABCDEF", $urandom_range(0, 2));
        end
        if ($urandom_range(0, 2) == 0) begin
          push_lex("p");
          if ($urandom_range(0, 5) != 0) push_lex(rand_from("+-"));
          push_some("0123456789", $urandom_range(0, 3));
        end
        push_suffix();
      end
      2: begin  // binary
        push_lex("0");
        push_lex(rand_from("bB"));
        push_some("01", $urandom_range(0, 5));
        push_suffix();
      end
      3: begin  // octal
        push_lex("0");
        push_some("01234567", $urandom_range(1, 4));
        push_suffix();
      end
      4: begin  // leading-zero fraction
        push_lex("0");
        push_lex(".");
        push_some("0123456789", $urandom_range(0, 3));
        push_suffix();
      end
      default: begin  // lone zero or a bad first character
        push_lex(rand_from("0ax.+u_"));
        push_some("0123456789", $urandom_range(0, 2));
      end
    endcase
    // terminator, or straight into the next literal
    case ($urandom_range(0, 3))
      0: push_raw(1'($urandom_range(0, 1)), char_t'($urandom_range(0, 255)));
      1: push_raw(1'b0, rand_from(" ;,)+-.e"));
      2: push_raw(1'b0, 8'h00);
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued characters, holds them until accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.start_req <= 1'b0;
      in_if.char_in   <= '0;
      lx        = LexStateClear;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      if (in_if.valid && in_if.ready) lex_predict(in_if.start_req, in_if.char_in);
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() != 0 &&
                     !(pend_q[0].drain_first && lex_res_q.size() != 0)) begin
          in_if.valid     <= 1'b1;
          in_if.start_req <= pend_q[0].start_req;
          in_if.char_in   <= pend_q[0].ch;
          void'(pend_q.pop_front());
          if (send_calm != 0) begin
            send_calm--;
          end else begin
            if ($urandom_range(0, 199) == 0) send_calm = 60;
            send_gap = idle_len();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random ready, one long hold-off, in-order result check.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap  = 0;
      recv_calm = 0;
      err_cnt   = 0;
      res_cnt   = 0;
      did_hold  = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        res_cnt++;
        if (lex_res_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("unexpected result: status %0d mode %0d", out_if.status_code,
                     out_if.mode_out);
        end else begin
          lex_res_t e;
          e = lex_res_q.pop_front();
          if (e.status !== out_if.status_code || e.mode !== out_if.mode_out ||
              e.dot !== out_if.has_dot || e.expo !== out_if.has_exponent ||
              e.u_suf !== out_if.unsigned_suffix || e.l_suf !== out_if.long_suffix ||
              e.f_suf !== out_if.float_suffix) begin
            err_cnt++;
            if (err_cnt <= MaxShown)
              $display("result %0d mismatch: exp st %0d md %0d d%0b e%0b u%0b l%0b f%0b,",
                       res_cnt, e.status, e.mode, e.dot, e.expo, e.u_suf, e.l_suf, e.f_suf,
                       " got st %0d md %0d d%0b e%0b u%0b l%0b f%0b",
                       out_if.status_code, out_if.mode_out, out_if.has_dot,
                       out_if.has_exponent, out_if.unsigned_suffix, out_if.long_suffix,
                       out_if.float_suffix);
          end
        end
        // long hold-off so the input side backs up
        if (res_cnt == HoldAt && !did_hold) begin
          did_hold = 1'b1;
          recv_gap = HoldLen;
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if (recv_calm != 0) begin
        recv_calm--;
        out_if.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) recv_calm = 60;
        recv_gap = idle_len();
        out_if.ready <= (recv_gap == 0);
        if (recv_gap != 0) recv_gap--;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    drain_pending   = 1'b0;
    n_items         = 0;

    // directed: empty prefixes, dangling point and sign, suffixes, extremes
    push_text("0x;");
    push_text("0Xp");
    push_text("0b2");
    push_text("1.;");
    push_text("1e-;");
    push_text("07Lu");
    push_raw(1'b1, 8'h00);
    push_raw(1'b1, 8'hFF);
    push_text("a7");   // bad first character, then read as after a leading zero

    // random literals with noise; drain the pipe at the start and midway
    drain_pending = 1'b1;
    while (n_items < NumItems) begin
      if (n_items >= NumItems / 2 && n_items < NumItems / 2 + 20) drain_pending = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3))
          push_raw(1'($urandom_range(0, 1)), char_t'($urandom_range(0, 255)));
      end else begin
        gen_literal();
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || in_if.valid || lex_res_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);

    if (err_cnt == 0 && lex_res_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/nll_pkg.sv
rtl/nll_intf.sv
rtl/numeric_literal_lexer_unit.sv
verif/tb.sv
